@@ design/pwsw_pkg.sv @@
// ----------------------------------------------------------------------------
// pwsw_pkg
// Types and constants shared by the pulse-width single-wire host.
// ----------------------------------------------------------------------------
`default_nettype none

package pwsw_pkg;

    // Largest response and command the link handles
    localparam int unsigned MAX_RESPONSE_BYTES = 8;
    localparam int unsigned MAX_COMMAND_BYTES  = 3;
    localparam int unsigned CMD_LEN_CAP =
        (MAX_COMMAND_BYTES < 3) ? MAX_COMMAND_BYTES : 3;

    // Input operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_HALF_US_TICKS   = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_BYTES  = 2'd1;
    localparam logic [1:0] CFG_EDGE_TIMEOUT    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TX     = 3'd1,
        PH_STOP   = 3'd2,
        PH_WAIT   = 3'd3,
        PH_SAMPLE = 3'd4,
        PH_GAP    = 3'd5
    } t_phase;

    typedef struct packed {
        logic        op;
        logic [23:0] command_word;
        logic [1:0]  command_length;
        logic        line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [2:0] rx_index;
        logic       done_res;
        logic       timed_out;
    } t_out_item;

    typedef struct packed {
        logic [7:0] half_us_ticks;
        logic [3:0] response_bytes;
        logic [4:0] edge_timeout_halves;
    } t_cfg;

endpackage

`default_nettype wire

@@ design/pwsw_core.sv @@
// ----------------------------------------------------------------------------
// pwsw_core
// Line timing state machine: one item per cycle, while i_fire is high, updates
// the state and forms the result for that item.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsw_core
    import pwsw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_out_item      o_res
);

    t_phase      r_phase,       n_phase;
    logic [13:0] r_tick,        n_tick;
    logic [23:0] r_cmd,         n_cmd;
    logic [4:0]  r_bits_left,   n_bits_left;
    logic [7:0]  r_rx_shift,    n_rx_shift;
    logic [2:0]  r_bit_in_byte, n_bit_in_byte;
    logic [3:0]  r_bytes_rcvd,  n_bytes_rcvd;

    logic [7:0]  w_h;
    logic [4:0]  w_lim;
    logic [4:0]  w_resp_len;
    logic [8:0]  w_h2;
    logic [9:0]  w_h3;
    logic [10:0] w_h6;
    logic [10:0] w_h8;
    logic [12:0] w_lim_h;
    logic [13:0] w_tick_inc;
    logic        w_tick;
    logic [1:0]  w_len;
    logic [7:0]  w_new_shift;
    logic [2:0]  w_bit_next;
    logic [3:0]  w_bytes_next;
    logic        w_byte_done;
    logic        w_resp_done;
    logic        w_tx_end;
    logic        w_stop_end;
    logic        w_tmo_end;
    logic        w_three_end;

    // Normalise the configuration: zero acts as one, clamp the response length
    assign w_h   = (i_cfg.half_us_ticks == 8'd0) ? 8'd1 : i_cfg.half_us_ticks;
    assign w_lim = (i_cfg.edge_timeout_halves == 5'd0) ? 5'd1 : i_cfg.edge_timeout_halves;

    always_comb begin
        if (i_cfg.response_bytes == 4'd0) begin
            w_resp_len = 5'd1;
        end else if ({1'b0, i_cfg.response_bytes} > 5'(MAX_RESPONSE_BYTES)) begin
            w_resp_len = 5'(MAX_RESPONSE_BYTES);
        end else begin
            w_resp_len = {1'b0, i_cfg.response_bytes};
        end
    end

    always_comb begin
        if (i_item.command_length == 2'd0) begin
            w_len = 2'd1;
        end else if (32'(i_item.command_length) > CMD_LEN_CAP) begin
            w_len = 2'(CMD_LEN_CAP);
        end else begin
            w_len = i_item.command_length;
        end
    end

    assign w_h2    = {w_h, 1'b0};
    assign w_h3    = {2'b00, w_h} + {1'b0, w_h, 1'b0};
    assign w_h6    = {w_h3, 1'b0};
    assign w_h8    = {w_h, 3'b000};
    assign w_lim_h = 13'(w_lim * w_h);

    assign w_tick       = i_fire && (i_item.op == OP_TICK);
    assign w_tick_inc   = r_tick + 14'd1;
    assign w_tx_end     = w_tick_inc >= {3'b000, w_h8};
    assign w_stop_end   = w_tick_inc >= {5'b00000, w_h2};
    assign w_tmo_end    = w_tick_inc >= {1'b0, w_lim_h};
    assign w_three_end  = w_tick_inc >= {4'b0000, w_h3};

    assign w_new_shift  = {r_rx_shift[6:0], i_item.line_level};
    assign w_bit_next   = r_bit_in_byte + 3'd1;
    assign w_byte_done  = (w_bit_next == 3'd0);
    assign w_bytes_next = r_bytes_rcvd + 4'd1;
    assign w_resp_done  = {1'b0, w_bytes_next} >= w_resp_len;

    // Next state
    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_cmd         = r_cmd;
        n_bits_left   = r_bits_left;
        n_rx_shift    = r_rx_shift;
        n_bit_in_byte = r_bit_in_byte;
        n_bytes_rcvd  = r_bytes_rcvd;
        if (i_fire && i_item.op == OP_START) begin
            // a start while busy is dropped
            if (r_phase == PH_IDLE) begin
                n_phase       = PH_TX;
                n_tick        = '0;
                n_cmd         = i_item.command_word;
                n_bits_left   = {w_len, 3'b000};
                n_rx_shift    = '0;
                n_bit_in_byte = '0;
                n_bytes_rcvd  = '0;
            end
        end else if (w_tick) begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_TX: begin
                    n_tick = w_tick_inc;
                    if (w_tx_end) begin
                        n_tick      = '0;
                        n_cmd       = {r_cmd[22:0], 1'b0};
                        n_bits_left = (r_bits_left == 5'd0) ? 5'd0 : r_bits_left - 5'd1;
                        if (r_bits_left <= 5'd1) begin
                            n_phase = PH_STOP;
                        end
                    end
                end
                PH_STOP: begin
                    n_tick = w_tick_inc;
                    if (w_stop_end) begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end
                end
                PH_WAIT: begin
                    if (!i_item.line_level) begin
                        n_phase = PH_SAMPLE;
                        n_tick  = '0;
                    end else begin
                        n_tick = w_tick_inc;
                        if (w_tmo_end) begin
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                        end
                    end
                end
                PH_SAMPLE: begin
                    n_tick = w_tick_inc;
                    if (w_three_end) begin
                        n_tick        = '0;
                        n_rx_shift    = w_new_shift;
                        n_bit_in_byte = w_bit_next;
                        n_phase       = PH_GAP;
                        if (w_byte_done) begin
                            n_bytes_rcvd = w_bytes_next;
                            if (w_resp_done) begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                end
                PH_GAP: begin
                    n_tick = w_tick_inc;
                    if (w_three_end) begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end
    end

    // Result for this item, taken from the state it leaves behind
    always_comb begin
        o_res = '0;
        o_res.rx_valid  = w_tick && (r_phase == PH_SAMPLE) && w_three_end && w_byte_done;
        o_res.rx_byte   = o_res.rx_valid ? w_new_shift : 8'd0;
        o_res.rx_index  = o_res.rx_valid ? r_bytes_rcvd[2:0] : 3'd0;
        o_res.done_res  = o_res.rx_valid && w_resp_done;
        o_res.timed_out = w_tick && (r_phase == PH_WAIT) && i_item.line_level && w_tmo_end;
        o_res.busy_res  = (n_phase != PH_IDLE);
        unique case (n_phase)
            PH_TX:   o_res.drive_low = n_cmd[23] ? (n_tick < {5'b00000, w_h2})
                                                 : (n_tick < {3'b000, w_h6});
            PH_STOP: o_res.drive_low = (n_tick < {5'b00000, w_h2});
            default: o_res.drive_low = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tick        <= '0;
            r_cmd         <= '0;
            r_bits_left   <= '0;
            r_rx_shift    <= '0;
            r_bit_in_byte <= '0;
            r_bytes_rcvd  <= '0;
        end else begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_cmd         <= n_cmd;
            r_bits_left   <= n_bits_left;
            r_rx_shift    <= n_rx_shift;
            r_bit_in_byte <= n_bit_in_byte;
            r_bytes_rcvd  <= n_bytes_rcvd;
        end
    end

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == 14'd0))
        else $error("tick count not clear while idle");

    a_tx_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TX) |-> (r_bits_left != 5'd0))
        else $error("sending with no command bits left");

    a_done_with_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> (o_res.rx_valid && !o_res.busy_res))
        else $error("done without a final byte");

    a_timeout_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.timed_out |=> (r_phase == PH_IDLE))
        else $error("timeout did not end the transaction");

endmodule

`default_nettype wire

@@ design/pwsw_obuf.sv @@
// ----------------------------------------------------------------------------
// pwsw_obuf
// Result register with a skid entry, so an item is still taken while the
// receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pwsw_obuf
    import pwsw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_out_item i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_item r_main;
    t_out_item r_skid;
    logic      w_accept;
    logic      w_taken;

    assign o_ready  = !r_skid_valid;
    assign w_accept = i_valid && o_ready;
    assign w_taken  = r_main_valid && i_ready;
    assign o_valid  = r_main_valid;
    assign o_data   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_taken || !r_main_valid) begin
            if (r_skid_valid) begin
                // promote the held transaction
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_taken || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end
        if (w_accept && r_main_valid && !w_taken) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held with empty result register");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && !i_ready && w_accept) |=> r_skid_valid)
        else $error("transaction lost during stall");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_main_valid && !r_skid_valid))
        else $error("skid entry not promoted");

endmodule

`default_nettype wire

@@ design/pulse_width_single_wire_host_unit.sv @@
// ----------------------------------------------------------------------------
// pulse_width_single_wire_host_unit
// Host end of a single-wire pulse-width-coded link, stepped one item a cycle while o_in_ready is high.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in): each transaction is either
// a time tick carrying the sampled line level, or a start request with up to
// three command bytes. Output channel (o_out_valid / i_out_ready / o_out):
// exactly one result per input transaction, in order, giving the drive level
// for the next tick, busy, and any received byte, done or timeout.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
// i_cfg_data): always ready; write only while no transaction is in flight.
// Each result is registered before it reaches o_out; the state machine update
// and the result are formed combinationally ahead of the result register.
// Throughput: one item per cycle while o_in_ready is high.
// A stalled receiver is absorbed by a result register plus one skid entry;
// o_in_ready falls only while both hold results.
// Reset (synchronous, active low) returns to idle with the line released and
// the configuration at its defaults (8, 8, 8).
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_single_wire_host_unit
    import pwsw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_out_item w_res;
    logic      w_fire;

    assign o_cfg_ready = 1'b1;
    assign w_fire      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_us_ticks       <= 8'd8;
            r_cfg.response_bytes      <= 4'd8;
            r_cfg.edge_timeout_halves <= 5'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_US_TICKS:  r_cfg.half_us_ticks       <= i_cfg_data;
                CFG_RESPONSE_BYTES: r_cfg.response_bytes      <= i_cfg_data[3:0];
                CFG_EDGE_TIMEOUT:   r_cfg.edge_timeout_halves <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    pwsw_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (i_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    pwsw_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (w_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse-width single-wire host unit.
// A directed table covers reset behaviour, refused starts, zero registers,
// the widest register values and both timeout and full-response endings.
// Random command and response traffic follows, with a simple responding
// device on the line. Every result is checked against either a fixed value
// from the directed table or an item-stepped prediction of the link.
// ----------------------------------------------------------------------------
module tb_top;
    import pwsw_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 300;

    typedef enum logic {ROW_ITEMS, ROW_REGS} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_in_item  item;
        int        reps;
        bit        typed;
        t_out_item want;
        t_cfg      regs;
    } t_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // Predicted link state and register copy
    t_cfg        link_cfg;
    t_phase      link_phase;
    logic [13:0] link_ticks;
    logic [23:0] link_cmd;
    logic [4:0]  link_bits_left;
    logic [7:0]  link_rx_shift;
    logic [2:0]  link_bit_pos;
    logic [3:0]  link_rx_count;

    // Responding device
    int   dev_hold;
    logic dev_bit;

    t_out_item due_reports[$];
    t_row      plan[$];
    int        errors = 0;
    int        cycles = 0;
    int        items_done = 0;
    int        bytes_seen = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_trigger = -1;
    bit        want_hold = 1'b0;
    int        stall_left = 0;

    pulse_width_single_wire_host_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned half_us();
        return (link_cfg.half_us_ticks == 0) ? 1 : link_cfg.half_us_ticks;
    endfunction

    // Advance the link by one item and form its result
    function automatic t_out_item link_step(input t_in_item it, output bit ignored);
        t_out_item   r;
        int unsigned h, lim, nlen, resp, low_len;
        r = '0;
        ignored = 1'b0;
        h = half_us();
        if (it.op == OP_START) begin
            if (link_phase == PH_IDLE) begin
                nlen = (it.command_length == 0) ? 1 : it.command_length;
                if (nlen > CMD_LEN_CAP) nlen = CMD_LEN_CAP;
                link_phase = PH_TX;
                link_ticks = '0;
                link_cmd = it.command_word;
                link_bits_left = 5'(8 * nlen);
                link_rx_shift = '0;
                link_bit_pos = '0;
                link_rx_count = '0;
            end else begin
                ignored = 1'b1;
            end
        end else begin
            case (link_phase)
                PH_TX: begin
                    link_ticks++;
                    if (link_ticks >= 8 * h) begin
                        link_ticks = '0;
                        link_cmd = link_cmd << 1;
                        if (link_bits_left != 0) link_bits_left--;
                        if (link_bits_left == 0) link_phase = PH_STOP;
                    end
                end
                PH_STOP: begin
                    link_ticks++;
                    if (link_ticks >= 2 * h) begin
                        link_phase = PH_WAIT;
                        link_ticks = '0;
                    end
                end
                PH_WAIT: begin
                    if (!it.line_level) begin
                        link_phase = PH_SAMPLE;
                        link_ticks = '0;
                    end else begin
                        lim = (link_cfg.edge_timeout_halves == 0) ? 1
                                                                  : link_cfg.edge_timeout_halves;
                        link_ticks++;
                        if (link_ticks >= lim * h) begin
                            r.timed_out = 1'b1;
                            link_phase = PH_IDLE;
                            link_ticks = '0;
                        end
                    end
                end
                PH_SAMPLE: begin
                    link_ticks++;
                    if (link_ticks >= 3 * h) begin
                        link_ticks = '0;
                        link_rx_shift = {link_rx_shift[6:0], it.line_level};
                        link_bit_pos++;
                        link_phase = PH_GAP;
                        if (link_bit_pos == 0) begin
                            resp = (link_cfg.response_bytes == 0) ? 1 : link_cfg.response_bytes;
                            if (resp > MAX_RESPONSE_BYTES) resp = MAX_RESPONSE_BYTES;
                            r.rx_valid = 1'b1;
                            r.rx_byte = link_rx_shift;
                            r.rx_index = link_rx_count[2:0];
                            link_rx_count++;
                            if (link_rx_count >= resp) begin
                                r.done_res = 1'b1;
                                link_phase = PH_IDLE;
                            end
                        end
                    end
                end
                PH_GAP: begin
                    link_ticks++;
                    if (link_ticks >= 3 * h) begin
                        link_phase = PH_WAIT;
                        link_ticks = '0;
                    end
                end
                default: begin
                    link_phase = PH_IDLE;
                    link_ticks = '0;
                end
            endcase
        end
        case (link_phase)
            PH_TX: begin
                low_len = link_cmd[23] ? 2 * h : 6 * h;
                r.drive_low = (link_ticks < low_len);
            end
            PH_STOP: r.drive_low = (link_ticks < 2 * h);
            default: r.drive_low = 1'b0;
        endcase
        r.busy_res = (link_phase != PH_IDLE);
        return r;
    endfunction

    // High ticks the device leaves before pulling the line low
    function automatic int pick_hold();
        int unsigned window;
        window = half_us() * ((link_cfg.edge_timeout_halves == 0) ? 1
                                                                  : link_cfg.edge_timeout_halves);
        case ($urandom_range(59))
            0: return window;
            1: return window - 1;
            default: return $urandom_range((window > 6) ? 5 : window - 1);
        endcase
    endfunction

    function automatic logic device_level();
        case (link_phase)
            PH_WAIT: begin
                if (dev_hold > 0) begin
                    dev_hold--;
                    return 1'b1;
                end
                dev_bit = 1'($urandom);
                return 1'b0;
            end
            PH_SAMPLE: return dev_bit;
            PH_GAP: return ($urandom_range(4) == 0) ? 1'($urandom) : 1'b1;
            default: return 1'($urandom);
        endcase
    endfunction

    // Hand one item over and record what it should produce
    task automatic offer(input t_in_item it, input bit typed, input t_out_item want);
        bit        ignored;
        t_phase    was;
        t_out_item r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        was = link_phase;
        r = link_step(it, ignored);
        due_reports.push_back(typed ? want : r);
        if (!ignored) items_done++;
        if (r.rx_valid) bytes_seen++;
        if (items_done == hold_trigger) begin
            want_hold = 1'b1;
            hold_trigger = -1;
        end
        if (link_phase == PH_WAIT && was != PH_WAIT) dev_hold = pick_hold();
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_HALF_US_TICKS:  link_cfg.half_us_ticks = data;
            CFG_RESPONSE_BYTES: link_cfg.response_bytes = data[3:0];
            CFG_EDGE_TIMEOUT:   link_cfg.edge_timeout_halves = data[4:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Drain, let the pipeline settle, then load all three registers
    task automatic write_regs(input t_cfg v);
        in_valid = 1'b0;
        while (due_reports.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        put_reg(CFG_HALF_US_TICKS, v.half_us_ticks);
        put_reg(CFG_RESPONSE_BYTES, {4'($urandom), v.response_bytes});
        put_reg(CFG_EDGE_TIMEOUT, {3'($urandom), v.edge_timeout_halves});
        cfg_valid = 1'b0;
    endtask

    task automatic run_traffic(input int min_items, input int min_bytes, input int pause_at);
        int       first_items, first_bytes;
        bit       paused;
        t_in_item it;
        first_items = items_done;
        first_bytes = bytes_seen;
        paused = 1'b0;
        while (items_done - first_items < min_items || bytes_seen - first_bytes < min_bytes
               || link_phase != PH_IDLE) begin
            it.op = OP_TICK;
            it.command_word = 24'($urandom);
            // mostly single-byte commands keep each transaction short
            it.command_length = ($urandom_range(7) == 0) ? 2'($urandom)
                                                         : 2'($urandom_range(1));
            it.line_level = 1'($urandom);
            if (link_phase == PH_IDLE) begin
                if ($urandom_range(99) < 75) it.op = OP_START;
            end else if ($urandom_range(99) < 2) begin
                it.op = OP_START;
            end else begin
                it.line_level = device_level();
            end
            offer(it, 1'b0, '0);
            // hold input back until the output side has caught up
            if (!paused && pause_at > 0 && items_done - first_items >= pause_at) begin
                paused = 1'b1;
                in_valid = 1'b0;
                while (due_reports.size() != 0) @(negedge clk);
            end
        end
    endtask

    function automatic void add_items(input logic op, input logic [23:0] word,
                                      input logic [1:0] len, input logic level, input int reps,
                                      input bit typed, input t_out_item want);
        t_row row;
        row.kind = ROW_ITEMS;
        row.item.op = op;
        row.item.command_word = word;
        row.item.command_length = len;
        row.item.line_level = level;
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        row.regs = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_regs(input t_cfg v);
        t_row row;
        row.kind = ROW_REGS;
        row.item = '0;
        row.reps = 0;
        row.typed = 1'b0;
        row.want = '0;
        row.regs = v;
        plan.push_back(row);
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk) begin
        if (want_hold) begin
            stall_left = LONG_HOLD;
            want_hold = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready = 1'b0;
        end else begin
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (due_reports.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, out_item);
                errors++;
            end else begin
                want = due_reports.pop_front();
                compare_field("drive_low", want.drive_low, out_item.drive_low);
                compare_field("busy_res", want.busy_res, out_item.busy_res);
                compare_field("rx_byte", want.rx_byte, out_item.rx_byte);
                compare_field("rx_valid", want.rx_valid, out_item.rx_valid);
                compare_field("rx_index", want.rx_index, out_item.rx_index);
                compare_field("done_res", want.done_res, out_item.done_res);
                compare_field("timed_out", want.timed_out, out_item.timed_out);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_out_item quiet, launched, expired;
        quiet = '0;
        launched = '0;
        launched.drive_low = 1'b1;
        launched.busy_res = 1'b1;
        expired = '0;
        expired.timed_out = 1'b1;

        link_cfg = {8'd8, 4'd8, 5'd8};
        link_phase = PH_IDLE;
        link_ticks = '0;
        link_cmd = '0;
        link_bits_left = '0;
        link_rx_shift = '0;
        link_bit_pos = '0;
        link_rx_count = '0;
        dev_hold = 0;
        dev_bit = 1'b1;

        // Reset settings: idle ticks, a zero-length start, a refused start;
        // zero registers then take over and the silent line times out
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b0, 1, 1'b1, quiet);
        add_items(OP_TICK, 24'hFFFFFF, 2'd3, 1'b1, 1, 1'b1, quiet);
        add_items(OP_START, 24'h800000, 2'd0, 1'b1, 1, 1'b1, launched);
        add_items(OP_START, 24'h000000, 2'd0, 1'b0, 1, 1'b1, launched);
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b1, 4, 1'b0, '0);
        add_regs({8'd0, 4'd0, 5'd0});
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b1, 62, 1'b0, '0);
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b1, 1, 1'b1, expired);
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b0, 1, 1'b1, quiet);
        // Zero registers act as one: short command, all-zero response byte
        add_items(OP_START, 24'h800000, 2'd1, 1'b1, 1, 1'b1, launched);
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b1, 66, 1'b0, '0);
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b0, 56, 1'b0, '0);
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b1, 3, 1'b1, quiet);
        // Widest timing, longest timeout, response length above range;
        // the free-running part carries this transaction on
        add_regs({8'd255, 4'd15, 5'd31});
        add_items(OP_START, 24'hA50000, 2'd1, 1'b1, 1, 1'b1, launched);
        add_items(OP_TICK, 24'h000000, 2'd0, 1'b1, 1, 1'b1, launched);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REGS) begin
                write_regs(plan[i].regs);
            end else begin
                repeat (plan[i].reps) offer(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        // Free running, with one long output stall early on
        hold_trigger = items_done + 40;
        write_regs({8'd1, 4'd1, 5'd3});
        run_traffic(40, 1, 0);

        send_idle_pct = 83;
        write_regs({8'd1, 4'd2, 5'd1});
        run_traffic(40, 1, 30);

        send_idle_pct = 0;
        stall_pct = 83;
        write_regs({8'd2, 4'd1, 5'd5});
        run_traffic(40, 1, 30);

        send_idle_pct = 38;
        stall_pct = 38;
        write_regs({8'd1, 4'd1, 5'd20});
        run_traffic(40, 1, 0);

        in_valid = 1'b0;
        while (due_reports.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ pulse_width_single_wire_host_unit.f @@
design/pwsw_pkg.sv
design/pwsw_core.sv
design/pwsw_obuf.sv
design/pulse_width_single_wire_host_unit.sv
bench/tb_top.sv
